[hw/rtl/csm_pkg.sv]
// Package for the clause subset matcher: sequencer states and result kinds.
package csm_pkg;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_STORE,
    ST_SCAN,
    ST_EMIT
  } csm_state_t;

  typedef enum logic [1:0] {
    KIND_STORED  = 2'd0,
    KIND_MATCH   = 2'd1,
    KIND_NOMATCH = 2'd2,
    KIND_FULL    = 2'd3
  } csm_kind_t;

endpackage

[hw/rtl/clause_subset_matcher.sv]
// Top level of the clause subset matcher: clause store and sequential subset search.
//
// Input channel (in_valid / in_stall) carries one item per handshake: op 0 is a
// fact of a clause being stored, op 1 is the state value of the next variable of
// a find stream. last closes either stream. The output channel (out_valid /
// out_stall) returns one item when a stream closes: the new clause index, store
// full, the first matching clause, or no match. num_vars is written through the
// cfg channel (cfg_ready is always high) and sets the length of a find stream.
// A store fact passes through ST_STORE, and also through ST_EMIT to post its
// result when it closes the clause. A find item scans the stored clauses in ST_SCAN
// (one clause per cycle through the shared compare and counter unit, stopping early
// once a clause completes), then passes through ST_EMIT to post the result on the
// closing item. One item is in work at a time; in_stall is high until it is done.
// After reset the requirement memory is cleared one entry per cycle, through all
// MAX_CLAUSES * 2**ceil(log2(MAX_VARS)) entries (16384 by default); no item is
// taken meanwhile. The result sits in an output register: the next item is
// accepted while it waits, and only a new result waits for a stalled receiver.
module clause_subset_matcher #(
  parameter int MAX_CLAUSES = 256,
  parameter int MAX_VARS    = 64,
  parameter int VALUE_BITS  = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       op,
  input  logic [5:0] var_index,
  input  logic [7:0] fact_value,
  input  logic       last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] kind,
  output logic [7:0] clause_index,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [6:0] num_vars
);
  import csm_pkg::*;

  localparam int VW    = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
  localparam int IW    = $clog2(MAX_CLAUSES);
  localparam int CW    = $clog2(MAX_CLAUSES + 1);
  localparam int PW    = $clog2(MAX_VARS + 1);
  localparam int AW    = IW + VW;
  localparam int DEPTH = MAX_CLAUSES * (2 ** VW);

  // Requirement memory: {valid, value} per (clause, variable).
  logic [VALUE_BITS:0] req_mem [DEPTH];
  logic [6:0]          size_mem [MAX_CLAUSES];
  logic [6:0]          cnt_mem [MAX_CLAUSES];

  csm_state_t state, state_next;

  logic [AW-1:0]         clr_addr;
  logic [6:0]            nv;
  logic [CW-1:0]         clause_count;
  logic [6:0]            pending;
  logic [PW-1:0]         pos;
  logic                  found;
  logic [IW-1:0]         found_idx;
  logic [VW-1:0]         var_r;
  logic [VALUE_BITS-1:0] val_r;
  logic                  last_r;
  logic                  var_ok_r;
  logic [CW-1:0]         scan_c;
  logic                  p_valid;
  logic [IW-1:0]         p_c;
  logic [VALUE_BITS:0]   req_rd;
  logic [6:0]            size_rd;
  logic [6:0]            cnt_rd;
  logic [1:0]            res_kind;
  logic [7:0]            res_idx;

  // Decoded input and helper values.
  logic [15:0]           fv_ext;
  logic [VALUE_BITS-1:0] val_in;
  logic [8:0]            var_ext;
  logic                  var_ok;
  logic                  slot_ok;
  logic [8:0]            eff_vars;
  logic [8:0]            pos_inc;
  logic                  closing;
  logic                  can_issue;
  logic                  scan_done;
  logic [6:0]            pending_next;
  logic [6:0]            cnt_old;
  logic [6:0]            cnt_new;
  logic                  hit;
  logic [11:0]           fi_ext;
  logic [11:0]           cc_ext;

  // Control from the output decode.
  logic                  in_acc;
  logic                  mem_we;
  logic [AW-1:0]         mem_wa;
  logic [VALUE_BITS:0]   mem_wd;
  logic [AW-1:0]         mem_ra;
  logic                  emit_go;

  assign fv_ext   = 16'(fact_value);
  assign val_in   = fv_ext[VALUE_BITS-1:0];
  assign var_ext  = 9'(var_index);
  assign var_ok   = var_ext < 9'(MAX_VARS);
  assign slot_ok  = clause_count < CW'(MAX_CLAUSES);
  assign eff_vars = (nv == 7'd0) ? 9'd1
                  : ((9'(nv) > 9'(MAX_VARS)) ? 9'(MAX_VARS) : 9'(nv));
  assign pos_inc  = 9'(pos) + 9'd1;
  assign closing  = last_r || (pos_inc >= eff_vars);
  assign can_issue = (scan_c < clause_count) && !found;
  assign scan_done = !can_issue && !p_valid;
  assign pending_next = pending + 7'((var_ok_r && slot_ok && !req_rd[VALUE_BITS]) ? 1 : 0);

  // Shared compare and counter unit for one clause of a find.
  assign cnt_old = (pos == '0) ? 7'd0 : cnt_rd;
  assign hit     = req_rd[VALUE_BITS] && (req_rd[VALUE_BITS-1:0] == val_r);
  assign cnt_new = hit ? cnt_old + 7'd1 : cnt_old;

  assign fi_ext = 12'(found_idx);
  assign cc_ext = 12'(clause_count);
  assign cfg_ready = 1'b1;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == AW'(DEPTH - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_next = op ? ST_SCAN : ST_STORE;
      end
      ST_STORE: begin
        state_next = last_r ? ST_EMIT : ST_IDLE;
      end
      ST_SCAN: begin
        if (scan_done) state_next = closing ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (!out_valid || !out_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_stall = 1'b1;
    in_acc   = 1'b0;
    mem_we   = 1'b0;
    mem_wa   = clr_addr;
    mem_wd   = '0;
    mem_ra   = {scan_c[IW-1:0], pos[VW-1:0]};
    emit_go  = 1'b0;
    case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        in_acc   = in_valid;
        mem_ra   = {clause_count[IW-1:0], var_ext[VW-1:0]};
      end
      ST_STORE: begin
        mem_we = var_ok_r && slot_ok;
        mem_wa = {clause_count[IW-1:0], var_r};
        mem_wd = {1'b1, val_r};
      end
      ST_SCAN: begin
      end
      ST_EMIT: begin
        emit_go = !out_valid || !out_stall;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Memories.
  always_ff @(posedge clk) begin
    if (mem_we) req_mem[mem_wa] <= mem_wd;
    req_rd <= req_mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (state == ST_STORE && last_r && slot_ok) size_mem[clause_count[IW-1:0]] <= pending_next;
    size_rd <= size_mem[scan_c[IW-1:0]];
  end

  // A newly closed clause starts with its counter at zero, even in mid-find.
  always_ff @(posedge clk) begin
    if (state == ST_SCAN && p_valid && !found) begin
      cnt_mem[p_c] <= cnt_new;
    end else if (state == ST_STORE && last_r && slot_ok) begin
      cnt_mem[clause_count[IW-1:0]] <= 7'd0;
    end
    cnt_rd <= cnt_mem[scan_c[IW-1:0]];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr     <= '0;
      nv           <= 7'd64;
      clause_count <= '0;
      pending      <= '0;
      pos          <= '0;
      found        <= 1'b0;
      found_idx    <= '0;
      scan_c       <= '0;
      p_valid      <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_valid) nv <= num_vars;
      if (state == ST_CLEAR) clr_addr <= clr_addr + AW'(1);
      if (emit_go) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      // Start a find item: clear the verdict on the first variable.
      if (in_acc && op) begin
        scan_c  <= '0;
        p_valid <= 1'b0;
        if (pos == '0) begin
          found     <= 1'b0;
          found_idx <= '0;
        end
      end
      if (state == ST_STORE) begin
        if (last_r) begin
          pending <= '0;
          if (slot_ok) clause_count <= clause_count + CW'(1);
        end else begin
          pending <= pending_next;
        end
      end
      if (state == ST_SCAN) begin
        // Advance one clause a cycle; hold the first to complete.
        p_valid <= can_issue;
        if (can_issue) scan_c <= scan_c + CW'(1);
        if (p_valid && !found && hit && size_rd != 7'd0 && cnt_new == size_rd) begin
          found     <= 1'b1;
          found_idx <= p_c;
        end
        if (scan_done) pos <= closing ? '0 : pos + PW'(1);
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      var_r    <= var_ext[VW-1:0];
      val_r    <= val_in;
      last_r   <= last;
      var_ok_r <= var_ok;
    end
    if (state == ST_SCAN) p_c <= scan_c[IW-1:0];
    if (state == ST_STORE) begin
      res_kind <= slot_ok ? KIND_STORED : KIND_FULL;
      res_idx  <= slot_ok ? cc_ext[7:0] : 8'd0;
    end
    if (state == ST_SCAN && scan_done) begin
      res_kind <= found ? KIND_MATCH : KIND_NOMATCH;
      res_idx  <= found ? fi_ext[7:0] : 8'd0;
    end
    if (emit_go) begin
      kind         <= res_kind;
      clause_index <= res_idx;
    end
  end

endmodule

[sim/testbench.sv]
// Testbench for the clause subset matcher: directed table plus random clause and find streams.
`timescale 1ns / 100ps

module testbench;
  import csm_pkg::*;

  localparam int NCL = 256;
  localparam int NVAR = 64;
  localparam int SETTLE = 400;   // idle wait, longer than one find item takes to finish

  typedef struct {
    logic      op;
    logic [5:0] var_i;
    logic [7:0] val;
    logic      lst;
    bit        typed;
    csm_kind_t kind;
    logic [7:0] idx;
  } row_t;

  typedef struct {
    csm_kind_t  kind;
    logic [7:0] idx;
  } verdict_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       op = 1'b0;
  logic [5:0] var_index = '0;
  logic [7:0] fact_value = '0;
  logic       last = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] kind;
  logic [7:0] clause_index;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [6:0] num_vars = 7'd64;

  clause_subset_matcher uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .var_index(var_index), .fact_value(fact_value), .last(last),
    .out_valid(out_valid), .out_stall(out_stall),
    .kind(kind), .clause_index(clause_index),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .num_vars(num_vars)
  );

  always #5 clk = ~clk;

  // Shadow copy of the clause store and the find sequencer
  bit         req_set [NCL][NVAR];
  logic [7:0] req_val [NCL][NVAR];
  int         clause_len [NCL];
  logic [6:0] hit_count [NCL];
  int         stored_clauses;
  int         scan_pos;
  bit         hit_found;
  int         hit_clause;
  logic [6:0] nv_reg = 7'd64;

  verdict_t   pending_verdicts[$];
  int         errors = 0;
  int         items_sent = 0;
  int         verdicts_seen = 0;
  int         n_match = 0, n_nomatch = 0, n_stored = 0, n_full = 0;
  bit         quiet_phase = 1'b0;

  function automatic int active_vars();
    int n;
    n = int'(nv_reg);
    if (n < 1) n = 1;
    if (n > NVAR) n = NVAR;
    return n;
  endfunction

  // Advance the shadow state by one accepted item; return 1 with a verdict when a stream closes
  function automatic bit advance_store(input logic o, input logic [5:0] v, input logic [7:0] d,
                                       input logic l, output verdict_t vr);
    int sz;
    if (o == 1'b0) begin
      if (stored_clauses < NCL) begin
        req_set[stored_clauses][v] = 1'b1;
        req_val[stored_clauses][v] = d;
      end
      if (!l) return 1'b0;
      if (stored_clauses >= NCL) begin
        vr.kind = KIND_FULL; vr.idx = 8'd0;
        return 1'b1;
      end
      sz = 0;
      for (int i = 0; i < NVAR; i++) if (req_set[stored_clauses][i]) sz++;
      clause_len[stored_clauses] = sz;
      vr.kind = KIND_STORED; vr.idx = stored_clauses[7:0];
      stored_clauses++;
      return 1'b1;
    end
    if (scan_pos == 0) begin
      for (int c = 0; c < NCL; c++) hit_count[c] = '0;
      hit_found = 1'b0;
      hit_clause = 0;
    end
    for (int c = 0; c < stored_clauses && !hit_found; c++) begin
      if (req_set[c][scan_pos] && req_val[c][scan_pos] == d) begin
        hit_count[c] = hit_count[c] + 7'd1;
        if (clause_len[c] != 0 && int'(hit_count[c]) == clause_len[c]) begin
          hit_found = 1'b1;
          hit_clause = c;
        end
      end
    end
    if (l || scan_pos + 1 >= active_vars()) begin
      scan_pos = 0;
      vr.kind = hit_found ? KIND_MATCH : KIND_NOMATCH;
      vr.idx = hit_found ? hit_clause[7:0] : 8'd0;
      return 1'b1;
    end
    scan_pos++;
    return 1'b0;
  endfunction

  // Offer one item after a gap (random unless quiet), hold it until taken, queue any verdict
  task automatic offer_item(input row_t r);
    verdict_t vr;
    int gap;
    gap = quiet_phase ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    op <= r.op;
    var_index <= r.var_i;
    fact_value <= r.val;
    last <= r.lst;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (advance_store(r.op, r.var_i, r.val, r.lst, vr)) begin
      if (r.typed) begin
        vr.kind = r.kind;
        vr.idx = r.idx;
      end
      pending_verdicts = {pending_verdicts, vr};
    end
    @(negedge clk);
  endtask

  function automatic row_t mk(input logic o, input int v, input int d, input logic l);
    row_t r;
    r.op = o; r.var_i = v[5:0]; r.val = d[7:0]; r.lst = l;
    r.typed = 1'b0; r.kind = KIND_STORED; r.idx = 8'd0;
    return r;
  endfunction

  function automatic row_t mkx(input logic o, input int v, input int d, input logic l,
                               input csm_kind_t k, input int ix);
    row_t r;
    r = mk(o, v, d, l);
    r.typed = 1'b1; r.kind = k; r.idx = ix[7:0];
    return r;
  endfunction

  // Drain, let the last item finish, then write num_vars
  task automatic set_num_vars(input logic [6:0] v);
    in_valid <= 1'b0;
    wait (pending_verdicts.size() == 0);
    repeat (SETTLE) @(negedge clk);
    cfg_valid <= 1'b1;
    num_vars <= v;
    do @(posedge clk); while (!cfg_ready);
    nv_reg = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(input int budget);
    int start, nf, n;
    row_t r;
    start = items_sent;
    while (items_sent - start < budget) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          // clause of 1..3 facts, mostly on live variables with a few values
          nf = $urandom_range(1, 3);
          for (int i = 0; i < nf; i++) begin
            r = mk(1'b0,
                   ($urandom_range(0, 5) == 0) ? $urandom_range(0, 63)
                                               : $urandom_range(0, active_vars() - 1),
                   ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                               : $urandom_range(0, 3),
                   i == nf - 1);
            offer_item(r);
          end
        end
        9: begin
          // noise: a short find or a lone closing fact with raw fields
          r = mk(1'($urandom_range(0, 1)), $urandom_range(0, 63), $urandom_range(0, 255),
                 1'b1);
          offer_item(r);
        end
        default: begin
          n = active_vars();
          for (int p = 0; p < n; p++) begin
            r = mk(1'b1, $urandom_range(0, 63),
                   ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                               : $urandom_range(0, 3),
                   (p + 1 == n) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 15) == 0));
            offer_item(r);
            if (r.lst) break;
          end
        end
      endcase
    end
  endtask

  // Stimulus
  initial begin
    row_t dir_rows[$];
    logic [6:0] nv_plan[10];
    nv_plan = '{7'd1, 7'd0, 7'd127, 7'd4, 7'd64, 7'd2, 7'd8, 7'd6, 7'd3, 7'd5};
    stored_clauses = 0;
    scan_pos = 0;
    hit_found = 1'b0;
    hit_clause = 0;

    // empty store, repeated variable, value extremes, interleaved store and find
    dir_rows = {dir_rows, mkx(1'b1, 0, 0, 1'b1, KIND_NOMATCH, 0)};
    dir_rows = {dir_rows, mk(1'b0, 0, 5, 1'b0)};
    dir_rows = {dir_rows, mkx(1'b0, 0, 7, 1'b1, KIND_STORED, 0)};
    dir_rows = {dir_rows, mk(1'b0, 63, 255, 1'b0)};
    dir_rows = {dir_rows, mkx(1'b0, 0, 0, 1'b1, KIND_STORED, 1)};
    dir_rows = {dir_rows, mk(1'b1, 0, 7, 1'b0)};
    dir_rows = {dir_rows, mk(1'b1, 0, 1, 1'b1)};
    dir_rows = {dir_rows, mk(1'b0, 1, 3, 1'b0)};
    dir_rows = {dir_rows, mk(1'b1, 0, 5, 1'b1)};
    dir_rows = {dir_rows, mkx(1'b0, 2, 3, 1'b1, KIND_STORED, 2)};
    dir_rows = {dir_rows, mk(1'b1, 0, 7, 1'b0)};
    dir_rows = {dir_rows, mkx(1'b0, 5, 9, 1'b1, KIND_STORED, 3)};
    dir_rows = {dir_rows, mk(1'b1, 0, 0, 1'b1)};
    dir_rows = {dir_rows, mk(1'b1, 0, 255, 1'b1)};
    dir_rows = {dir_rows, mk(1'b1, 0, 0, 1'b0)};
    dir_rows = {dir_rows, mk(1'b1, 0, 3, 1'b1)};

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) offer_item(dir_rows[i]);

    // one setting per phase; odd phases run with no idling on either side
    for (int ph = 0; ph < 10; ph++) begin
      set_num_vars(nv_plan[ph]);
      quiet_phase = ph[0];
      random_phase(170);
    end
    in_valid <= 1'b0;

    wait (pending_verdicts.size() == 0);
    repeat (SETTLE) @(negedge clk);
    $display("Covered %0d items: %0d stored, %0d full, %0d matches, %0d misses.",
             items_sent, n_stored, n_full, n_match, n_nomatch);
    if (errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  // Result receiver: random stall per item, one long hold-off to back up the input
  initial begin
    int w;
    bit held;
    verdict_t exp_v;
    held = 1'b0;
    forever begin
      if (!held && verdicts_seen == 40) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (800) @(negedge clk);
      end
      w = quiet_phase ? 0 : $urandom_range(0, 10);
      if (w > 0) begin
        out_stall <= 1'b1;
        repeat (w) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      verdicts_seen++;
      case (kind)
        KIND_MATCH: n_match++;
        KIND_NOMATCH: n_nomatch++;
        KIND_STORED: n_stored++;
        default: n_full++;
      endcase
      if (pending_verdicts.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: unexpected result kind=%0d index=%0d", kind, clause_index);
      end else begin
        exp_v = pending_verdicts.pop_front();
        if (kind !== exp_v.kind || clause_index !== exp_v.idx) begin
          errors++;
          if (errors <= 10)
            $display("ERROR: result %0d expected kind=%0d index=%0d, got kind=%0d index=%0d",
                     verdicts_seen, exp_v.kind, exp_v.idx, kind, clause_index);
        end
      end
      @(negedge clk);
    end
  end

  // Watchdog
  initial begin
    #50ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

[clause_subset_matcher.f]
hw/rtl/csm_pkg.sv
hw/rtl/clause_subset_matcher.sv
sim/testbench.sv
